[rtl/core/bsat_pkg.sv]
// Shared types and constants for the sighting aging table.
// Holds the command codes, tracker class codes, the stored entry layout
// and the tracker class decode; no dependencies.
package bsat_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_class;

    localparam t_cmd CMD_SIGHT = 2'd0;
    localparam t_cmd CMD_PRUNE = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;

    localparam t_class CLS_NONE     = 2'd0;
    localparam t_class CLS_AIRTAG   = 2'd1;
    localparam t_class CLS_TILE     = 2'd2;
    localparam t_class CLS_SMARTTAG = 2'd3;

    localparam logic [1:0] CFG_STALE_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_COUNT_WINDOW = 2'd1;

    localparam logic [31:0] STALE_LIMIT_RST  = 32'd20000;
    localparam logic [31:0] COUNT_WINDOW_RST = 32'd30000;
    localparam logic [31:0] TIME_MAX         = 32'hFFFF_FFFF;

    localparam logic [15:0] COMPANY_APPLE = 16'h004C;
    localparam logic [7:0]  APPLE_FINDMY  = 8'h12;

    typedef struct packed {
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [15:0] company;
        logic        has_mfr;
        t_class      cls;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
    } t_entry;

    // Service flags are only consulted when the manufacturer pattern misses.
    function automatic t_class tracker_decode(
        input logic        has_mfr,
        input logic [15:0] company,
        input logic        third_valid,
        input logic [7:0]  third_byte,
        input logic        svc_feed,
        input logic        svc_fd5a
    );
        t_class cls;
        if (has_mfr && company == COMPANY_APPLE && third_valid && third_byte == APPLE_FINDMY) begin
            cls = CLS_AIRTAG;
        end else if (svc_feed) begin
            cls = CLS_TILE;
        end else if (svc_fd5a) begin
            cls = CLS_SMARTTAG;
        end else begin
            cls = CLS_NONE;
        end
        return cls;
    endfunction

endpackage

[rtl/core/bsat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ble_sighting_aging_table_unit.sv]
// Top level of the sighting aging table: command sequencer, scan datapath and ports.
// Depends on bsat_pkg and bsat_ram.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-----------------------------------------
//  command  | i_in_valid   | o_in_ready   | i_cmd, i_now_ms, i_mac_address, ...
//  result   | o_out_valid  | i_out_ready  | o_slot, o_newly_created, ... counts
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A command's result is offered after one walk over the entry RAM at one read per cycle
// and a final write in the ST_FIN state.
// A new command is taken in the cycle after the previous result has been transferred
// at the earliest; the unit does not take a command while one is in flight.
// Reset clears the valid and written flags at once; entries never written read as zero.
// The config port is always ready.
module ble_sighting_aging_table_unit
    import bsat_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [31:0]        i_now_ms,
    input  logic [47:0]        i_mac_address,
    input  logic signed [7:0]  i_rssi_dbm,
    input  logic               i_has_mfr_data,
    input  logic [15:0]        i_company_code,
    input  logic               i_mfr_third_valid,
    input  logic [7:0]         i_mfr_third_byte,
    input  logic               i_svc_feed,
    input  logic               i_svc_fd5a,
    input  logic [4:0]         i_entry_index,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [4:0]         o_slot,
    output logic               o_newly_created,
    output logic               o_slot_valid,
    output logic [47:0]        o_out_mac,
    output logic signed [7:0]  o_out_rssi,
    output logic [15:0]        o_out_company,
    output logic               o_out_has_mfr,
    output logic [1:0]         o_tracker_class,
    output logic [31:0]        o_created_ms,
    output logic [31:0]        o_refreshed_ms,
    output logic [5:0]         o_active_count,
    output logic [5:0]         o_tracker_count
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int CWX = (CW > 6) ? CW : 6;
    localparam int SW  = (IW > 5) ? IW : 5;
    localparam int EW  = $bits(t_entry);
    localparam logic [IW:0]   ENTRY_CNT = (IW + 1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state, n_state;

    // Config registers.
    logic [31:0] r_stale, r_window;

    // Latched command.
    t_cmd        r_cmd;
    logic [31:0] r_now;
    logic [47:0] r_mac;
    logic [7:0]  r_rssi;
    logic        r_mfr;
    logic [15:0] r_company;
    t_class      r_cls;
    logic [4:0]  r_eidx;

    // Per-entry flags.
    logic [ENTRIES-1:0] r_valid, r_wr;

    // Scan pipeline.
    logic [IW:0]   r_cnt;
    logic          r_dv;
    logic [IW-1:0] r_didx;
    logic          w_rd_en;
    logic [EW-1:0] w_ram_q;
    t_entry        w_ent;
    logic [31:0]   w_age;
    logic          w_v, w_stale, w_v_after, w_c, w_t;

    // Scan results.
    logic [CW-1:0] r_act, r_trk;
    logic          r_hit, r_hc, r_ht;
    logic [IW-1:0] r_hidx;
    logic [31:0]   r_hfirst;
    logic          r_hfree;
    logic [IW-1:0] r_fidx;
    logic [31:0]   r_oldt;
    logic [IW-1:0] r_oidx;
    logic          r_oc, r_ot;
    logic          w_old_upd;
    t_entry        r_rd;
    logic          r_rv;

    // Final write.
    logic [IW-1:0] w_s;
    logic          w_created, w_old_a, w_old_t, w_new_a, w_new_t;
    logic [31:0]   w_first;
    logic [CW-1:0] w_act_fin, w_trk_fin;
    logic [CWX-1:0] w_act_x, w_trk_x;
    logic [SW-1:0] w_slot_x;
    t_entry        w_wentry;
    logic          w_we;

    logic w_in_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_DONE);
    assign w_in_xfer   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale  <= STALE_LIMIT_RST;
            r_window <= COUNT_WINDOW_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STALE_LIMIT:  r_stale  <= i_cfg_data;
                CFG_COUNT_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_xfer) n_state = ST_SCAN;
            ST_SCAN: if (r_dv && r_didx == LAST_IDX) n_state = ST_FIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd     <= i_cmd;
            r_now     <= i_now_ms;
            r_mac     <= i_mac_address;
            r_rssi    <= $unsigned(i_rssi_dbm);
            r_mfr     <= i_has_mfr_data;
            r_company <= i_has_mfr_data ? i_company_code : 16'd0;
            r_cls     <= tracker_decode(i_has_mfr_data, i_company_code, i_mfr_third_valid,
                                        i_mfr_third_byte, i_svc_feed, i_svc_fd5a);
            r_eidx    <= i_entry_index;
        end
    end

    // Entry RAM walk: the data for address i returns in the cycle after the address goes out.
    assign w_rd_en = (r_state == ST_SCAN) && (r_cnt < ENTRY_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cnt <= '0;
        end else if (w_rd_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_rd_en) begin
            r_didx <= r_cnt[IW-1:0];
        end
    end

    bsat_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s),
        .i_wdata (w_wentry),
        .i_re    (w_rd_en),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_ram_q)
    );

    // An entry never written reads as zero.
    assign w_ent     = r_wr[r_didx] ? t_entry'(w_ram_q) : '0;
    assign w_age     = r_now - w_ent.last_ms;
    assign w_v       = r_valid[r_didx];
    assign w_stale   = w_age > r_stale;
    assign w_v_after = w_v && !(r_cmd == CMD_PRUNE && w_stale);
    assign w_c       = w_v_after && (w_age < r_window);
    assign w_t       = w_c && (w_ent.cls != CLS_NONE);
    assign w_old_upd = w_v && (w_ent.last_ms < r_oldt);

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_act   <= '0;
            r_trk   <= '0;
            r_hit   <= 1'b0;
            r_hfree <= 1'b0;
            r_oldt  <= TIME_MAX;
            r_oidx  <= '0;
            r_rv    <= 1'b0;
            r_rd    <= '0;
        end else if (r_dv) begin
            r_act <= r_act + CW'(w_c);
            r_trk <= r_trk + CW'(w_t);
            if (w_v && w_ent.mac == r_mac && !r_hit) begin
                r_hit    <= 1'b1;
                r_hidx   <= r_didx;
                r_hfirst <= w_ent.first_ms;
                r_hc     <= w_c;
                r_ht     <= w_t;
            end
            if (!w_v && !r_hfree) begin
                r_hfree <= 1'b1;
                r_fidx  <= r_didx;
            end
            if (w_old_upd) begin
                r_oldt <= w_ent.last_ms;
                r_oidx <= r_didx;
            end
            // Slot 0 is the eviction victim until a strictly older entry shows up.
            if (w_old_upd || r_didx == '0) begin
                r_oc <= w_c;
                r_ot <= w_t;
            end
            if (9'(r_didx) == 9'(r_eidx)) begin
                r_rd <= w_ent;
                r_rv <= w_v;
            end
        end
    end

    // Final slot choice and count correction for the written entry.
    always_comb begin
        if (r_hit) begin
            w_s       = r_hidx;
            w_created = 1'b0;
            w_old_a   = r_hc;
            w_old_t   = r_ht;
            w_first   = r_hfirst;
        end else if (r_hfree) begin
            w_s       = r_fidx;
            w_created = 1'b1;
            w_old_a   = 1'b0;
            w_old_t   = 1'b0;
            w_first   = r_now;
        end else begin
            w_s       = r_oidx;
            w_created = 1'b1;
            w_old_a   = r_oc;
            w_old_t   = r_ot;
            w_first   = r_now;
        end
        w_new_a = (r_window != 32'd0);
        w_new_t = w_new_a && (r_cls != CLS_NONE);
        w_we    = (r_state == ST_FIN) && (r_cmd == CMD_SIGHT);
        if (w_we) begin
            w_act_fin = r_act - CW'(w_old_a) + CW'(w_new_a);
            w_trk_fin = r_trk - CW'(w_old_t) + CW'(w_new_t);
        end else begin
            w_act_fin = r_act;
            w_trk_fin = r_trk;
        end
        w_wentry.mac      = r_mac;
        w_wentry.rssi     = r_rssi;
        w_wentry.company  = r_company;
        w_wentry.has_mfr  = r_mfr;
        w_wentry.cls      = r_cls;
        w_wentry.first_ms = w_first;
        w_wentry.last_ms  = r_now;
        w_act_x  = CWX'(w_act_fin);
        w_trk_x  = CWX'(w_trk_fin);
        w_slot_x = SW'(w_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wr    <= '0;
        end else if (r_dv && r_cmd == CMD_PRUNE && w_v && w_stale) begin
            r_valid[r_didx] <= 1'b0;
        end else if (w_we) begin
            r_valid[w_s] <= 1'b1;
            r_wr[w_s]    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            o_active_count  <= (w_act_x > CWX'(63)) ? 6'd63 : w_act_x[5:0];
            o_tracker_count <= (w_trk_x > CWX'(63)) ? 6'd63 : w_trk_x[5:0];
            if (r_cmd == CMD_SIGHT) begin
                o_slot          <= w_slot_x[4:0];
                o_newly_created <= w_created;
                o_slot_valid    <= 1'b1;
                o_out_mac       <= w_wentry.mac;
                o_out_rssi      <= $signed(w_wentry.rssi);
                o_out_company   <= w_wentry.company;
                o_out_has_mfr   <= w_wentry.has_mfr;
                o_tracker_class <= w_wentry.cls;
                o_created_ms    <= w_wentry.first_ms;
                o_refreshed_ms  <= w_wentry.last_ms;
            end else if (r_cmd == CMD_READ) begin
                o_slot          <= r_eidx;
                o_newly_created <= 1'b0;
                o_slot_valid    <= r_rv;
                o_out_mac       <= r_rd.mac;
                o_out_rssi      <= $signed(r_rd.rssi);
                o_out_company   <= r_rd.company;
                o_out_has_mfr   <= r_rd.has_mfr;
                o_tracker_class <= r_rd.cls;
                o_created_ms    <= r_rd.first_ms;
                o_refreshed_ms  <= r_rd.last_ms;
            end else begin
                o_slot          <= 5'd0;
                o_newly_created <= 1'b0;
                o_slot_valid    <= 1'b0;
                o_out_mac       <= 48'd0;
                o_out_rssi      <= 8'sd0;
                o_out_company   <= 16'd0;
                o_out_has_mfr   <= 1'b0;
                o_tracker_class <= CLS_NONE;
                o_created_ms    <= 32'd0;
                o_refreshed_ms  <= 32'd0;
            end
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("command taken while a result is pending");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SCAN && !r_dv))
        else $error("scan did not start after a command transfer");

    a_sight_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cmd == CMD_SIGHT) |-> (o_slot_valid && r_valid[w_s]))
        else $error("sighting result points at a free slot");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tracker_count <= o_active_count))
        else $error("tracker count exceeds active count");

endmodule

[tb/sv/tb_ble_sighting_aging_table_unit.sv]
// Self-checking testbench for the sighting aging table unit.
// Drives commands and register writes, predicts every result with its own table
// model and compares field by field. Depends on bsat_pkg and the unit's RTL.
module tb_ble_sighting_aging_table_unit
    import bsat_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   NUM_SLOTS    = 32;
    localparam int   MAC_POOL     = 40;
    localparam int   RAND_PER_SET = 70;
    localparam int   DRAIN_CYCLES = NUM_SLOTS + 8;
    localparam t_cmd CMD_UNUSED   = 2'd3;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] now_ms;
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic        has_mfr;
        logic [15:0] company;
        logic        third_valid;
        logic [7:0]  third_byte;
        logic        svc_feed;
        logic        svc_fd5a;
        logic [4:0]  entry_index;
    } sight_cmd_t;

    typedef struct packed {
        logic [4:0]  slot;
        logic        created;
        logic        slot_valid;
        logic [47:0] mac;
        logic [7:0]  rssi;
        logic [15:0] company;
        logic        has_mfr;
        t_class      cls;
        logic [31:0] first_ms;
        logic [31:0] last_ms;
        logic [5:0]  active;
        logic [5:0]  trackers;
    } table_result_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        o_cfg_ready;

    logic        in_valid  = 1'b0;
    sight_cmd_t  drv_item  = '0;
    logic        o_in_ready;
    logic        out_ready = 1'b0;

    logic              o_out_valid;
    logic [4:0]        o_slot;
    logic              o_newly_created;
    logic              o_slot_valid;
    logic [47:0]       o_out_mac;
    logic signed [7:0] o_out_rssi;
    logic [15:0]       o_out_company;
    logic              o_out_has_mfr;
    logic [1:0]        o_tracker_class;
    logic [31:0]       o_created_ms;
    logic [31:0]       o_refreshed_ms;
    logic [5:0]        o_active_count;
    logic [5:0]        o_tracker_count;

    // Shadow copy of the entry store and the two registers.
    logic        st_valid   [NUM_SLOTS];
    logic [47:0] st_mac     [NUM_SLOTS];
    logic [7:0]  st_rssi    [NUM_SLOTS];
    logic [15:0] st_company [NUM_SLOTS];
    logic        st_mfr     [NUM_SLOTS];
    t_class      st_cls     [NUM_SLOTS];
    logic [31:0] st_first   [NUM_SLOTS];
    logic [31:0] st_last    [NUM_SLOTS];
    logic [31:0] cur_stale_ms  = STALE_LIMIT_RST;
    logic [31:0] cur_window_ms = COUNT_WINDOW_RST;

    sight_cmd_t    pending_cmds[$];
    table_result_t expected_results[$];
    table_result_t want;

    logic [47:0] mac_pool [MAC_POOL];
    logic [31:0] sim_now = '0;

    int send_idle_pct  = 24;
    int recv_stall_pct = 58;
    int err_count      = 0;
    int cmds_sent      = 0;
    int results_seen   = 0;
    int n_created      = 0;
    int n_evicted      = 0;
    int n_pruned       = 0;

    ble_sighting_aging_table_unit #(
        .ENTRIES (NUM_SLOTS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (drv_item.cmd),
        .i_now_ms          (drv_item.now_ms),
        .i_mac_address     (drv_item.mac),
        .i_rssi_dbm        (drv_item.rssi),
        .i_has_mfr_data    (drv_item.has_mfr),
        .i_company_code    (drv_item.company),
        .i_mfr_third_valid (drv_item.third_valid),
        .i_mfr_third_byte  (drv_item.third_byte),
        .i_svc_feed        (drv_item.svc_feed),
        .i_svc_fd5a        (drv_item.svc_fd5a),
        .i_entry_index     (drv_item.entry_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_slot            (o_slot),
        .o_newly_created   (o_newly_created),
        .o_slot_valid      (o_slot_valid),
        .o_out_mac         (o_out_mac),
        .o_out_rssi        (o_out_rssi),
        .o_out_company     (o_out_company),
        .o_out_has_mfr     (o_out_has_mfr),
        .o_tracker_class   (o_tracker_class),
        .o_created_ms      (o_created_ms),
        .o_refreshed_ms    (o_refreshed_ms),
        .o_active_count    (o_active_count),
        .o_tracker_count   (o_tracker_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 50) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      results_seen, name, got, exp_val));
        end
    endtask

    function automatic table_result_t slot_view(input int unsigned idx);
        table_result_t r;
        r            = '0;
        r.slot       = idx[4:0];
        r.slot_valid = st_valid[idx];
        r.mac        = st_mac[idx];
        r.rssi       = st_rssi[idx];
        r.company    = st_company[idx];
        r.has_mfr    = st_mfr[idx];
        r.cls        = st_cls[idx];
        r.first_ms   = st_first[idx];
        r.last_ms    = st_last[idx];
        return r;
    endfunction

    // Applies one command to the shadow store and returns the result it should produce.
    function automatic table_result_t predict_table(input sight_cmd_t c);
        table_result_t r;
        int unsigned   i, s, free_i, old_i, act, trk;
        logic          found, have_free;
        logic [31:0]   old_t, age;
        t_class        cls;
        r         = '0;
        found     = 1'b0;
        have_free = 1'b0;
        s         = 0;
        free_i    = 0;
        old_i     = 0;
        old_t     = TIME_MAX;
        act       = 0;
        trk       = 0;
        case (c.cmd)
            CMD_SIGHT: begin
                for (i = 0; i < NUM_SLOTS; i++) begin
                    if (!found) begin
                        if (st_valid[i] && st_mac[i] == c.mac) begin
                            found = 1'b1;
                            s     = i;
                        end else begin
                            if (!st_valid[i] && !have_free) begin
                                have_free = 1'b1;
                                free_i    = i;
                            end
                            // Strictly smaller, so ties keep the lowest index.
                            if (st_valid[i] && st_last[i] < old_t) begin
                                old_t = st_last[i];
                                old_i = i;
                            end
                        end
                    end
                end
                if (!found) begin
                    s = have_free ? free_i : old_i;
                    if (!have_free) n_evicted++;
                    n_created++;
                    st_valid[s] = 1'b1;
                    st_mac[s]   = c.mac;
                    st_first[s] = c.now_ms;
                end
                if (c.has_mfr && c.company == COMPANY_APPLE && c.third_valid &&
                    c.third_byte == APPLE_FINDMY) begin
                    cls = CLS_AIRTAG;
                end else if (c.svc_feed) begin
                    cls = CLS_TILE;
                end else if (c.svc_fd5a) begin
                    cls = CLS_SMARTTAG;
                end else begin
                    cls = CLS_NONE;
                end
                st_rssi[s]    = c.rssi;
                st_company[s] = c.has_mfr ? c.company : 16'h0000;
                st_mfr[s]     = c.has_mfr;
                st_last[s]    = c.now_ms;
                st_cls[s]     = cls;
                r             = slot_view(s);
                r.created     = !found;
            end
            CMD_PRUNE: begin
                for (i = 0; i < NUM_SLOTS; i++) begin
                    age = c.now_ms - st_last[i];
                    if (st_valid[i] && age > cur_stale_ms) begin
                        st_valid[i] = 1'b0;
                        n_pruned++;
                    end
                end
            end
            CMD_READ: begin
                r = slot_view(c.entry_index);
            end
            default: begin
            end
        endcase
        for (i = 0; i < NUM_SLOTS; i++) begin
            age = c.now_ms - st_last[i];
            if (st_valid[i] && age < cur_window_ms) begin
                act++;
                if (st_cls[i] != CLS_NONE) trk++;
            end
        end
        r.active   = act[5:0];
        r.trackers = trk[5:0];
        return r;
    endfunction

    // Command driver: presents the next pending command and predicts it on transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(predict_table(drv_item));
                cmds_sent++;
            end
            if (!in_valid || o_in_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result for slot %0d with no command pending",
                                              o_slot));
                end else begin
                    want = expected_results.pop_front();
                    check_field("slot", o_slot, want.slot);
                    check_field("newly_created", o_newly_created, want.created);
                    check_field("slot_valid", o_slot_valid, want.slot_valid);
                    check_field("out_mac", o_out_mac, want.mac);
                    check_field("out_rssi", $unsigned(o_out_rssi), want.rssi);
                    check_field("out_company", o_out_company, want.company);
                    check_field("out_has_mfr", o_out_has_mfr, want.has_mfr);
                    check_field("tracker_class", o_tracker_class, want.cls);
                    check_field("created_ms", o_created_ms, want.first_ms);
                    check_field("refreshed_ms", o_refreshed_ms, want.last_ms);
                    check_field("active_count", o_active_count, want.active);
                    check_field("tracker_count", o_tracker_count, want.trackers);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [47:0] fresh_mac();
        logic [31:0] hi, lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[15:0], lo};
    endfunction

    function automatic logic [47:0] pick_mac();
        if ($urandom_range(99) < 85) return mac_pool[$urandom_range(MAC_POOL - 1)];
        return fresh_mac();
    endfunction

    function automatic sight_cmd_t random_fields();
        sight_cmd_t  it;
        logic [31:0] w0, w1, w2, w3;
        w0             = $urandom;
        w1             = $urandom;
        w2             = $urandom;
        w3             = $urandom;
        it.cmd         = w0[1:0];
        it.now_ms      = w1;
        it.mac         = {w2[15:0], w3};
        it.rssi        = w0[9:2];
        it.has_mfr     = w0[10];
        it.company     = w0[26:11];
        it.third_valid = w0[27];
        it.third_byte  = w2[23:16];
        it.svc_feed    = w0[28];
        it.svc_fd5a    = w0[29];
        it.entry_index = w2[28:24];
        return it;
    endfunction

    // Content is biased toward the tracker patterns so that every class shows up.
    function automatic sight_cmd_t sighting_item(input logic [31:0] now,
                                                 input logic [47:0] mac);
        sight_cmd_t it;
        it        = random_fields();
        it.cmd    = CMD_SIGHT;
        it.now_ms = now;
        it.mac    = mac;
        if ($urandom_range(2) == 0) it.company = COMPANY_APPLE;
        if ($urandom_range(2) == 0) it.third_byte = APPLE_FINDMY;
        it.svc_feed = ($urandom_range(3) == 0);
        it.svc_fd5a = ($urandom_range(3) == 0);
        return it;
    endfunction

    function automatic sight_cmd_t plain_item(input t_cmd cmd, input logic [31:0] now,
                                              input logic [4:0] idx);
        sight_cmd_t it;
        it             = random_fields();
        it.cmd         = cmd;
        it.now_ms      = now;
        it.entry_index = idx;
        return it;
    endfunction

    task automatic advance_clock();
        int r;
        r = $urandom_range(99);
        if (r < 2) begin
            sim_now = $urandom;
        end else if (r < 10) begin
            sim_now = sim_now + $urandom_range(40000, 20000);
        end else if (r < 25) begin
            sim_now = sim_now;
        end else begin
            sim_now = sim_now + $urandom_range(3000, 1);
        end
    endtask

    task automatic directed_run();
        sight_cmd_t it;
        int         j;
        // Read of a slot that was never written.
        pending_cmds.push_back(plain_item(CMD_READ, 32'd0, 5'd0));
        // Lowest address, weakest signal, full tracker pattern.
        it             = sighting_item(32'd0, 48'h0);
        it.rssi        = 8'h80;
        it.has_mfr     = 1'b1;
        it.company     = COMPANY_APPLE;
        it.third_valid = 1'b1;
        it.third_byte  = APPLE_FINDMY;
        pending_cmds.push_back(it);
        // Highest address, strongest signal, service flags only.
        it             = sighting_item(32'd1, 48'hFFFF_FFFF_FFFF);
        it.rssi        = 8'h7F;
        it.has_mfr     = 1'b1;
        it.company     = 16'hFFFF;
        it.third_valid = 1'b0;
        it.svc_feed    = 1'b1;
        it.svc_fd5a    = 1'b1;
        pending_cmds.push_back(it);
        // Refresh of an existing entry; the pattern misses without the manufacturer flag.
        it             = sighting_item(32'd100, 48'h0);
        it.has_mfr     = 1'b0;
        it.company     = COMPANY_APPLE;
        it.third_valid = 1'b1;
        it.third_byte  = APPLE_FINDMY;
        it.svc_feed    = 1'b0;
        it.svc_fd5a    = 1'b1;
        pending_cmds.push_back(it);
        // Third byte off by one gives no class.
        it             = sighting_item(32'd200, 48'h1);
        it.has_mfr     = 1'b1;
        it.company     = COMPANY_APPLE;
        it.third_valid = 1'b1;
        it.third_byte  = APPLE_FINDMY + 8'd1;
        it.svc_feed    = 1'b0;
        it.svc_fd5a    = 1'b0;
        pending_cmds.push_back(it);
        pending_cmds.push_back(plain_item(CMD_READ, 32'd300, 5'd0));
        pending_cmds.push_back(plain_item(CMD_READ, 32'd300, 5'd1));
        pending_cmds.push_back(plain_item(CMD_READ, 32'd300, 5'd2));
        pending_cmds.push_back(plain_item(CMD_READ, 32'd300, 5'd31));
        // Age exactly at the stale limit survives; an entry older than that is freed.
        pending_cmds.push_back(plain_item(CMD_PRUNE, 32'd20100, 5'd0));
        pending_cmds.push_back(plain_item(CMD_READ, 32'd20100, 5'd1));
        pending_cmds.push_back(plain_item(CMD_UNUSED, 32'd20100, 5'd3));
        // Time stamps that straddle the wrap of the millisecond counter.
        pending_cmds.push_back(sighting_item(32'hFFFF_FFF0, 48'hA5A5_5A5A_A5A5));
        pending_cmds.push_back(plain_item(CMD_PRUNE, 32'h0000_0010, 5'd0));
        pending_cmds.push_back(plain_item(CMD_READ, 32'h0000_0010, 5'd1));
        // Fill the table at the latest time stamp, then evict: slot 0 must be taken.
        for (j = 0; j <= NUM_SLOTS; j++) begin
            pending_cmds.push_back(sighting_item(TIME_MAX, fresh_mac()));
        end
        pending_cmds.push_back(plain_item(CMD_READ, TIME_MAX, 5'd0));
    endtask

    task automatic random_run(input int n);
        int k, j, r;
        for (k = 0; k < n; k++) begin
            advance_clock();
            r = $urandom_range(99);
            if (r < 3) begin
                // A burst of new devices at one time stamp forces evictions with ties.
                for (j = 0; j < 8; j++) begin
                    pending_cmds.push_back(sighting_item(sim_now, fresh_mac()));
                end
            end else if (r < 70) begin
                pending_cmds.push_back(sighting_item(sim_now, pick_mac()));
            end else if (r < 82) begin
                pending_cmds.push_back(plain_item(CMD_PRUNE, sim_now, 5'd0));
            end else if (r < 97) begin
                pending_cmds.push_back(plain_item(CMD_READ, sim_now, 5'($urandom_range(31))));
            end else begin
                pending_cmds.push_back(plain_item(CMD_UNUSED, sim_now, 5'd0));
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_STALE_LIMIT) begin
            cur_stale_ms = data;
        end else if (idx == CFG_COUNT_WINDOW) begin
            cur_window_ms = data;
        end
    endtask

    // Sampled at the falling edge so that the driver's updates have settled.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic pick_setting(input int idx, output logic [31:0] stale,
                                output logic [31:0] window);
        case (idx)
            0:       begin stale = STALE_LIMIT_RST; window = COUNT_WINDOW_RST; end
            1:       begin stale = 32'd0;           window = TIME_MAX;         end
            2:       begin stale = TIME_MAX;        window = 32'd0;            end
            3:       begin stale = 32'd5000;        window = 32'd12000;        end
            4: begin
                stale  = $urandom_range(60000);
                window = $urandom_range(60000);
            end
            default: begin stale = 32'd1500;        window = TIME_MAX;         end
        endcase
    endtask

    initial begin
        int          i, p, h, k;
        logic [31:0] stale, window;
        for (i = 0; i < NUM_SLOTS; i++) begin
            st_valid[i]   = 1'b0;
            st_mac[i]     = '0;
            st_rssi[i]    = '0;
            st_company[i] = '0;
            st_mfr[i]     = 1'b0;
            st_cls[i]     = CLS_NONE;
            st_first[i]   = '0;
            st_last[i]    = '0;
        end
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        for (i = 2; i < MAC_POOL; i++) mac_pool[i] = fresh_mac();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers stay at their reset values for the directed part.
        directed_run();
        sim_now = 32'hFFF8_0000;
        for (p = 0; p < 3; p++) begin
            for (h = 0; h < 2; h++) begin
                wait_idle();
                if (h == 0) begin
                    send_idle_pct  = (p == 0) ? 24 : (p == 1) ? 58 : 0;
                    recv_stall_pct = (p == 0) ? 58 : (p == 1) ? 24 : 0;
                end
                pick_setting(2 * p + h, stale, window);
                cfg_write(CFG_STALE_LIMIT, stale);
                cfg_write(CFG_COUNT_WINDOW, window);
                random_run(RAND_PER_SET);
            end
        end

        for (k = 0; k < 20000 && (pending_cmds.size() != 0 || in_valid ||
                                   expected_results.size() != 0); k++) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Sent %0d commands over six register settings, checked %0d results.",
                 cmds_sent, results_seen);
        $display("Entries created %0d, evicted %0d, pruned %0d; mismatches %0d.",
                 n_created, n_evicted, n_pruned, err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
